/* src/grsp_pkg.sv */
// Shared types and codes for the generational reference-counted slot pool.
`default_nettype none

package grsp_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0] FUNC_ADDREF  = 2'd2;
  localparam logic [1:0] FUNC_RELEASE = 2'd3;

  // Status codes carried in the status field.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // Request transaction payload.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  slot_index;
    logic [15:0] handle_gen;
  } req_t;

  // Response transaction payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_index;
    logic [15:0] out_gen;
    logic [15:0] ref_count;
    logic        freed;
  } rsp_t;

  // Operations of the shared step unit.
  typedef enum logic [1:0] {
    UNIT_INC,
    UNIT_DEC,
    UNIT_INC_WRAP
  } unit_op_t;

endpackage

`default_nettype wire

/* src/generational_refcounted_slot_pool.sv */
// Top level of the generational reference-counted slot pool.
`default_nettype none

// The pool hands out slots as handles made of an index and a generation, each slot
// carrying a reference count. One request is handled at a time: a request is taken
// only while the sequencer is idle, and a finished response waits in its own register
// so that the next request can be taken while the response is still pending. Lookup,
// add-reference, allocation of a never-used slot, a release that keeps the slot live,
// an invalid handle and a full pool go from the read step straight to the done step;
// allocation from the free stack adds a generation-read step, and a release that frees
// the slot a bump step. The added steps come from the registered read of the per-slot
// memories and from the single step unit, used once for the count and once more for
// the generation bump. While an earlier response still waits in the response register
// when the result is ready, the sequencer holds in its last step until that response
// is taken. No clearing pass is needed after reset.
module generational_refcounted_slot_pool #(
  parameter int SLOT_COUNT = 256,
  parameter int GEN_BITS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire grsp_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output grsp_pkg::rsp_t      rsp
);

  localparam int IW    = $clog2(SLOT_COUNT);
  localparam int PW    = IW + 1;
  localparam int CMP_W = (PW > 8) ? PW : 8;
  localparam int HW    = (GEN_BITS > 16) ? GEN_BITS : 16;
  localparam int CXW   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int UW    = (GEN_BITS > COUNT_BITS) ? GEN_BITS : COUNT_BITS;

  localparam logic [PW-1:0]         SLOT_LIMIT = PW'(SLOT_COUNT);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [GEN_BITS-1:0]   GEN_MAX    = {GEN_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_BUMP,
    S_ALLOC_GEN,
    S_DONE
  } state_t;

  state_t            state;
  grsp_pkg::req_t    cur;
  logic [IW-1:0]     slot;
  logic [PW-1:0]     used_slots;
  logic [PW-1:0]     free_top;
  grsp_pkg::rsp_t    res;
  logic              rsp_load;

  // Memory ports.
  logic                  gen_we, cnt_we, stk_we;
  logic [IW-1:0]         gen_waddr, cnt_waddr, stk_waddr;
  logic [GEN_BITS-1:0]   gen_wdata;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [IW-1:0]         stk_wdata;
  logic [IW-1:0]         gen_raddr, cnt_raddr, stk_raddr;
  logic [GEN_BITS-1:0]   gen_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [IW-1:0]         stk_rd;

  // Shared step unit.
  grsp_pkg::unit_op_t unit_op;
  logic [UW-1:0]      unit_a;
  logic [UW-1:0]      unit_res;
  logic               unit_zero;

  // Derived values.
  logic [CMP_W-1:0]      idx_in_ext, idx_cur_ext, used_ext;
  logic [PW-1:0]         top_dec;
  logic [IW-1:0]         new_slot;
  logic [CMP_W-1:0]      new_slot_ext, slot_ext;
  logic [HW-1:0]         hgen_ext, gen_rd_ext, gen_bump_ext;
  logic [CXW-1:0]        cnt_rd_ext, cnt_after_ext;
  logic [COUNT_BITS-1:0] cnt_after;
  logic [GEN_BITS-1:0]   gen_bump;
  logic                  is_alloc, hit, saturated, stack_nonempty, room_left;

  assign idx_in_ext     = CMP_W'(req.slot_index);
  assign idx_cur_ext    = CMP_W'(cur.slot_index);
  assign used_ext       = CMP_W'(used_slots);
  assign top_dec        = free_top - PW'(1);
  assign stack_nonempty = (free_top != '0);
  assign room_left      = (used_slots < SLOT_LIMIT);
  assign new_slot       = stack_nonempty ? stk_rd : used_slots[IW-1:0];
  assign new_slot_ext   = CMP_W'(new_slot);
  assign slot_ext       = CMP_W'(slot);
  assign hgen_ext       = HW'(cur.handle_gen);
  assign gen_rd_ext     = HW'(gen_rd);
  assign cnt_rd_ext     = CXW'(cnt_rd);
  assign cnt_after      = unit_res[COUNT_BITS-1:0];
  assign cnt_after_ext  = CXW'(cnt_after);
  assign gen_bump       = unit_res[GEN_BITS-1:0];
  assign gen_bump_ext   = HW'(gen_bump);
  assign is_alloc       = (cur.func == grsp_pkg::FUNC_ALLOC);
  assign saturated      = (cnt_rd == COUNT_MAX);

  // Handle check: non-null, below the high-water mark, matching generation, live slot.
  assign hit = (cur.handle_gen != 16'd0) && (idx_cur_ext < used_ext) &&
               (hgen_ext == gen_rd_ext) && (cnt_rd != '0);

  // Reads: the stack top; the request index while idle, then the slot being worked on.
  assign stk_raddr = top_dec[IW-1:0];
  assign cnt_raddr = (state == S_IDLE) ? idx_in_ext[IW-1:0] : slot;
  always_comb begin
    if (state == S_IDLE) begin
      gen_raddr = idx_in_ext[IW-1:0];
    end else if (state == S_READ && is_alloc) begin
      gen_raddr = stk_rd;
    end else begin
      gen_raddr = slot;
    end
  end

  // Step unit operand selection.
  always_comb begin
    if (state == S_BUMP) begin
      unit_op = grsp_pkg::UNIT_INC_WRAP;
      unit_a  = UW'(gen_rd);
    end else if (cur.func == grsp_pkg::FUNC_RELEASE) begin
      unit_op = grsp_pkg::UNIT_DEC;
      unit_a  = UW'(cnt_rd);
    end else begin
      unit_op = grsp_pkg::UNIT_INC;
      unit_a  = UW'(cnt_rd);
    end
  end

  grsp_step_unit #(.W(UW)) u_step (
    .op      (unit_op),
    .operand (unit_a),
    .limit   (UW'(GEN_MAX)),
    .result  (unit_res),
    .is_zero (unit_zero)
  );

  // Memory write control.
  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = slot;
    gen_wdata = GEN_BITS'(1);
    cnt_we    = 1'b0;
    cnt_waddr = slot;
    cnt_wdata = cnt_after;
    stk_we    = 1'b0;
    stk_waddr = free_top[IW-1:0];
    stk_wdata = slot;
    case (state)
      S_READ: begin
        if (is_alloc) begin
          if (stack_nonempty) begin
            cnt_we    = 1'b1;
            cnt_waddr = stk_rd;
            cnt_wdata = COUNT_BITS'(1);
          end else if (room_left) begin
            gen_we    = 1'b1;
            gen_waddr = used_slots[IW-1:0];
            cnt_we    = 1'b1;
            cnt_waddr = used_slots[IW-1:0];
            cnt_wdata = COUNT_BITS'(1);
          end
        end else if (hit) begin
          if (cur.func == grsp_pkg::FUNC_RELEASE) begin
            cnt_we = 1'b1;
          end else if (cur.func == grsp_pkg::FUNC_ADDREF && !saturated) begin
            cnt_we = 1'b1;
          end
        end
      end
      S_BUMP: begin
        gen_we    = 1'b1;
        gen_wdata = gen_bump;
        stk_we    = (free_top < SLOT_LIMIT);
      end
      default: begin
      end
    endcase
  end

  grsp_ram #(.DEPTH(SLOT_COUNT), .WIDTH(GEN_BITS)) u_gen_ram (
    .clk (clk), .we (gen_we), .waddr (gen_waddr), .wdata (gen_wdata),
    .raddr (gen_raddr), .rdata (gen_rd)
  );

  grsp_ram #(.DEPTH(SLOT_COUNT), .WIDTH(COUNT_BITS)) u_cnt_ram (
    .clk (clk), .we (cnt_we), .waddr (cnt_waddr), .wdata (cnt_wdata),
    .raddr (cnt_raddr), .rdata (cnt_rd)
  );

  grsp_ram #(.DEPTH(SLOT_COUNT), .WIDTH(IW)) u_stack_ram (
    .clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
    .raddr (stk_raddr), .rdata (stk_rd)
  );

  assign req_ready = (state == S_IDLE);

  // The finished result moves into the response register once that register is free.
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Sequencer, pool counters and response registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_slots <= '0;
      free_top   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            slot  <= idx_in_ext[IW-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          res.freed <= 1'b0;
          if (is_alloc) begin
            if (stack_nonempty) begin
              free_top <= top_dec;
              slot     <= stk_rd;
              state    <= S_ALLOC_GEN;
            end else if (room_left) begin
              used_slots    <= used_slots + PW'(1);
              res.status    <= grsp_pkg::ST_OK;
              res.out_index <= new_slot_ext[7:0];
              res.out_gen   <= 16'd1;
              res.ref_count <= 16'd1;
              state         <= S_DONE;
            end else begin
              res.status    <= grsp_pkg::ST_FULL;
              res.out_index <= 8'd0;
              res.out_gen   <= 16'd0;
              res.ref_count <= 16'd0;
              state         <= S_DONE;
            end
          end else if (!hit) begin
            res.status    <= grsp_pkg::ST_INVALID;
            res.out_index <= cur.slot_index;
            res.out_gen   <= 16'd0;
            res.ref_count <= 16'd0;
            state         <= S_DONE;
          end else begin
            res.out_index <= cur.slot_index;
            res.out_gen   <= gen_rd_ext[15:0];
            case (cur.func)
              grsp_pkg::FUNC_LOOKUP: begin
                res.status    <= grsp_pkg::ST_OK;
                res.ref_count <= cnt_rd_ext[15:0];
                state         <= S_DONE;
              end
              grsp_pkg::FUNC_ADDREF: begin
                if (saturated) begin
                  res.status    <= grsp_pkg::ST_SATURATED;
                  res.ref_count <= cnt_rd_ext[15:0];
                end else begin
                  res.status    <= grsp_pkg::ST_OK;
                  res.ref_count <= cnt_after_ext[15:0];
                end
                state <= S_DONE;
              end
              grsp_pkg::FUNC_RELEASE: begin
                res.status    <= grsp_pkg::ST_OK;
                res.ref_count <= cnt_after_ext[15:0];
                state         <= unit_zero ? S_BUMP : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_BUMP: begin
          if (free_top < SLOT_LIMIT) begin
            free_top <= free_top + PW'(1);
          end
          res.status    <= grsp_pkg::ST_OK;
          res.out_gen   <= gen_bump_ext[15:0];
          res.ref_count <= 16'd0;
          res.freed     <= 1'b1;
          state         <= S_DONE;
        end
        S_ALLOC_GEN: begin
          res.status    <= grsp_pkg::ST_OK;
          res.out_index <= slot_ext[7:0];
          res.out_gen   <= gen_rd_ext[15:0];
          res.ref_count <= 16'd1;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The free stack never holds more slots than have ever been handed out.
  a_top_le_used: assert property (@(posedge clk) disable iff (rst)
    free_top <= used_slots)
    else $error("free stack deeper than high-water mark");

  // The high-water mark never passes the pool size.
  a_used_le_limit: assert property (@(posedge clk) disable iff (rst)
    used_slots <= SLOT_LIMIT)
    else $error("high-water mark beyond pool size");

  // A freeing release always reports success with a zero count.
  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.freed |-> rsp.status == grsp_pkg::ST_OK && rsp.ref_count == 16'd0)
    else $error("freed response with bad status or count");

  // A full pool is only reported once every slot has been used.
  a_full_used: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == grsp_pkg::ST_FULL |-> used_slots == SLOT_LIMIT)
    else $error("pool full reported with unused slots left");
`endif

endmodule

`default_nettype wire

/* src/grsp_ram.sv */
// Simple memory with one write port and one registered read port.
`default_nettype none

module grsp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/grsp_step_unit.sv */
// Shared increment and decrement unit for counts and generations.
`default_nettype none

module grsp_step_unit #(
  parameter int W = 16
) (
  input  wire grsp_pkg::unit_op_t op,
  input  wire logic [W-1:0]       operand,
  input  wire logic [W-1:0]       limit,
  output logic      [W-1:0]       result,
  output logic                    is_zero
);

  // Step by one; the wrapping increment goes from the limit back to one.
  always_comb begin
    case (op)
      grsp_pkg::UNIT_DEC:      result = operand - W'(1);
      grsp_pkg::UNIT_INC_WRAP: result = (operand >= limit) ? W'(1) : operand + W'(1);
      default:                 result = operand + W'(1);
    endcase
  end

  assign is_zero = (result == '0);

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the generational reference-counted slot pool.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SLOTS = 256;
  localparam logic [15:0] GEN_TOP = 16'hFFFF;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam int unsigned MAX_GAP = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  grsp_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  grsp_pkg::rsp_t rsp;

  // Shadow copy of the pool, advanced once per accepted request transaction.
  int high_water = 0;
  int free_depth = 0;
  logic [7:0] free_list [POOL_SLOTS];
  logic [15:0] slot_gen [POOL_SLOTS];
  logic [15:0] slot_cnt [POOL_SLOTS];

  grsp_pkg::rsp_t expected_rsps [$];
  grsp_pkg::rsp_t granted;
  int err_count = 0;
  int unsigned next_gap = 0;
  int unsigned sink_wait = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  generational_refcounted_slot_pool u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // A handle is live when it is not null, lies below the high-water mark,
  // carries the current generation and the slot still holds references.
  function automatic bit handle_live(logic [7:0] idx, logic [15:0] g);
    return g != 16'd0 && int'(idx) < high_water && slot_gen[idx] == g &&
           slot_cnt[idx] != 16'd0;
  endfunction

  // Apply one request to the shadow pool and return the response it must produce.
  function automatic grsp_pkg::rsp_t pool_step(grsp_pkg::req_t r);
    grsp_pkg::rsp_t e;
    int s;
    e = '0;
    if (r.func == grsp_pkg::FUNC_ALLOC) begin
      s = -1;
      if (free_depth > 0) begin
        free_depth--;
        s = int'(free_list[free_depth]);
      end else if (high_water < POOL_SLOTS) begin
        s = high_water;
        high_water++;
        slot_gen[s] = 16'd1;
      end
      if (s < 0) begin
        e.status = grsp_pkg::ST_FULL;
      end else begin
        slot_cnt[s] = 16'd1;
        e.status = grsp_pkg::ST_OK;
        e.out_index = 8'(s);
        e.out_gen = slot_gen[s];
        e.ref_count = 16'd1;
      end
    end else if (!handle_live(r.slot_index, r.handle_gen)) begin
      e.status = grsp_pkg::ST_INVALID;
      e.out_index = r.slot_index;
    end else begin
      s = int'(r.slot_index);
      e.status = grsp_pkg::ST_OK;
      e.out_index = r.slot_index;
      case (r.func)
        grsp_pkg::FUNC_ADDREF: begin
          if (slot_cnt[s] == COUNT_TOP) e.status = grsp_pkg::ST_SATURATED;
          else slot_cnt[s] = slot_cnt[s] + 16'd1;
        end
        grsp_pkg::FUNC_RELEASE: begin
          slot_cnt[s] = slot_cnt[s] - 16'd1;
          // The last reference retires the handle; generation 0 is skipped on wrap.
          if (slot_cnt[s] == 16'd0) begin
            slot_gen[s] = (slot_gen[s] == GEN_TOP) ? 16'd1 : slot_gen[s] + 16'd1;
            free_list[free_depth] = r.slot_index;
            free_depth++;
            e.freed = 1'b1;
          end
        end
        default: ;
      endcase
      e.out_gen = slot_gen[s];
      e.ref_count = slot_cnt[s];
    end
    return e;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Send one request transaction; valid stays high across back-to-back sends.
  task automatic send_req(input logic [1:0] f, input logic [7:0] idx, input logic [15:0] g);
    grsp_pkg::req_t item;
    item = '{func: f, slot_index: idx, handle_gen: g};
    repeat (next_gap) @(posedge clk);
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    granted = pool_step(item);
    expected_rsps.insert(expected_rsps.size(), granted);
    next_gap = $urandom_range(0, MAX_GAP);
    if (next_gap != 0) req_valid <= 1'b0;
  endtask

  // Stop sending and wait until every outstanding response has come back.
  task automatic wait_drained();
    if (next_gap == 0) req_valid <= 1'b0;
    next_gap = 0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Response side: random stalls between transactions, field-by-field compare.
  always @(posedge clk) begin : rsp_check
    grsp_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          note_mismatch("unexpected response", 64'(rsp), 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) note_mismatch("status", rsp.status, want.status);
          if (rsp.out_index !== want.out_index)
            note_mismatch("out_index", rsp.out_index, want.out_index);
          if (rsp.out_gen !== want.out_gen) note_mismatch("out_gen", rsp.out_gen, want.out_gen);
          if (rsp.ref_count !== want.ref_count)
            note_mismatch("ref_count", rsp.ref_count, want.ref_count);
          if (rsp.freed !== want.freed) note_mismatch("freed", rsp.freed, want.freed);
        end
        sink_wait = $urandom_range(0, MAX_GAP);
      end
      if (sink_wait != 0) begin
        rsp_ready <= 1'b0;
        sink_wait--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Handle checks on an empty pool, reuse through the free stack, stale handles.
  task automatic test_directed();
    logic [7:0] a, b;
    logic [15:0] ga, gb;
    send_req(grsp_pkg::FUNC_LOOKUP, 8'd0, 16'd1);
    send_req(grsp_pkg::FUNC_RELEASE, 8'd0, 16'd0);
    send_req(grsp_pkg::FUNC_ALLOC, 8'hFF, 16'hFFFF);
    a = granted.out_index;
    ga = granted.out_gen;
    send_req(grsp_pkg::FUNC_ALLOC, 8'd0, 16'd0);
    b = granted.out_index;
    gb = granted.out_gen;
    send_req(grsp_pkg::FUNC_LOOKUP, a, ga);
    send_req(grsp_pkg::FUNC_LOOKUP, a, 16'd0);
    send_req(grsp_pkg::FUNC_LOOKUP, a, ga + 16'd1);
    send_req(grsp_pkg::FUNC_ADDREF, 8'hFF, 16'hFFFF);
    send_req(grsp_pkg::FUNC_ADDREF, a, ga);
    // Two references: the first release keeps the slot live, the second frees it.
    send_req(grsp_pkg::FUNC_RELEASE, a, ga);
    send_req(grsp_pkg::FUNC_RELEASE, a, ga);
    send_req(grsp_pkg::FUNC_RELEASE, a, ga);
    send_req(grsp_pkg::FUNC_LOOKUP, a, ga + 16'd1);
    send_req(grsp_pkg::FUNC_ADDREF, a, ga + 16'd1);
    send_req(grsp_pkg::FUNC_ALLOC, 8'h55, 16'hAAAA);
    ga = granted.out_gen;
    send_req(grsp_pkg::FUNC_RELEASE, b, gb);
    send_req(grsp_pkg::FUNC_RELEASE, a, ga);
    // The free stack is last in, first out.
    send_req(grsp_pkg::FUNC_ALLOC, 8'd0, 16'd0);
    send_req(grsp_pkg::FUNC_ALLOC, 8'd0, 16'd0);
    send_req(grsp_pkg::FUNC_LOOKUP, b, gb + 16'd1);
    wait_drained();
  endtask

  // Exhaust every slot, hit the full status, then retire everything.
  task automatic test_pool_full();
    int s;
    while (free_depth != 0 || high_water < POOL_SLOTS)
      send_req(grsp_pkg::FUNC_ALLOC, 8'($urandom), 16'($urandom));
    send_req(grsp_pkg::FUNC_ALLOC, 8'($urandom), 16'($urandom));
    send_req(grsp_pkg::FUNC_ALLOC, 8'hFF, 16'hFFFF);
    send_req(grsp_pkg::FUNC_LOOKUP, 8'hFF, slot_gen[255]);
    for (s = 0; s < POOL_SLOTS; s++)
      while (slot_cnt[s] != 16'd0) send_req(grsp_pkg::FUNC_RELEASE, 8'(s), slot_gen[s]);
    send_req(grsp_pkg::FUNC_LOOKUP, 8'hFF, slot_gen[255]);
    wait_drained();
  endtask

  // Mostly well-formed handle traffic on live slots, plus stale handles and noise.
  task automatic test_random_traffic(input int n);
    int live [$];
    int k, s, pick;
    int unsigned roll;
    logic [15:0] g;
    for (k = 0; k < n; k++) begin
      live.delete();
      for (s = 0; s < high_water; s++)
        if (slot_cnt[s] != 16'd0) live.insert(live.size(), s);
      roll = $urandom_range(0, 99);
      if (roll < 20 || live.size() == 0) begin
        send_req(grsp_pkg::FUNC_ALLOC, 8'($urandom), 16'($urandom));
      end else if (roll < 85) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        if (roll < 35) send_req(grsp_pkg::FUNC_LOOKUP, 8'(pick), slot_gen[pick]);
        else if (roll < 50) send_req(grsp_pkg::FUNC_ADDREF, 8'(pick), slot_gen[pick]);
        else send_req(grsp_pkg::FUNC_RELEASE, 8'(pick), slot_gen[pick]);
      end else if (roll < 93) begin
        // Null, stale or future generation, or the current one of any slot, live or retired.
        pick = $urandom_range(0, high_water - 1);
        case ($urandom_range(0, 3))
          0: g = 16'd0;
          1: g = slot_gen[pick] - 16'd1;
          2: g = slot_gen[pick] + 16'd1;
          default: g = slot_gen[pick];
        endcase
        send_req(2'($urandom_range(1, 3)), 8'(pick), g);
      end else begin
        send_req(2'($urandom), 8'($urandom), 16'($urandom));
      end
    end
    wait_drained();
  endtask

  initial begin : run
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_full();
    test_random_traffic(950);
    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/grsp_pkg.sv
src/grsp_ram.sv
src/grsp_step_unit.sv
src/generational_refcounted_slot_pool.sv
bench/testbench.sv
